/* design/mrse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrse_pkg: shared types and constants for the rank/select engine
// Request layouts, operation and order codes, and sizing defaults.
// ----------------------------------------------------------------------------
package mrse_pkg;

    // Sizing
    localparam int MRSE_MAX_RECORDS = 1024;
    localparam int MRSE_QDEPTH      = 4;
    localparam int KEY_W            = 31;
    localparam int RANK_W           = 11;
    localparam int OUT_IDX_W        = 10;

    // Operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ORDER = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Order codes
    localparam logic [1:0] ORD_LOAD  = 2'd0;
    localparam logic [1:0] ORD_CHEAP = 2'd1;
    localparam logic [1:0] ORD_DEAR  = 2'd2;
    localparam logic [1:0] ORD_RELEV = 2'd3;

    // Status codes
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    typedef struct packed {
        logic [1:0]        operation;
        logic [KEY_W-1:0]  price;
        logic [KEY_W-1:0]  relevance;
        logic [1:0]        order_select;
        logic [RANK_W-1:0] rank_position;
    } t_in_item;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] record_index;
        logic                 status;
    } t_out_item;

    // Back end status, seen by the top level checks
    typedef struct packed {
        logic in_load;
        logic lists_busy;
    } t_back_stat;

endpackage : mrse_pkg
`default_nettype wire

/* design/multi_key_rank_select_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_key_rank_select_engine: rank/select over three sorted record orders
// Loads insert into price-ascending, price-descending and relevance lists;
// queries return the load index at a 1-based rank in the selected order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
//  During a load the list walk moves one entry per cycle through each list
//  memory's single write port. A query makes at most one registered list
//  read.
//  A 4-deep request queue takes requests while a load runs or a result waits.
//  Reset is synchronous; list memories need no clearing pass.
// ----------------------------------------------------------------------------
module multi_key_rank_select_engine import mrse_pkg::*; #(
    parameter int MAX_RECORDS = MRSE_MAX_RECORDS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_data
);

    logic       w_cmd_valid, w_cmd_pop;
    t_in_item   w_cmd;
    t_back_stat w_stat;

    // Intake and queue
    mrse_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_pop(w_cmd_pop)
    );

    // Execution
    mrse_back #(.MAX_RECORDS(MAX_RECORDS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_cmd_pop(w_cmd_pop),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_data(o_out_data), .o_stat(w_stat)
    );

    // Checks
    a_range_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_RANGE)) |->
        (o_out_data.record_index == '0))
        else $error("out of range result carries a nonzero index");

    a_reset_no_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_walk_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.lists_busy |-> w_stat.in_load)
        else $error("list walk active outside a load");

    a_no_pop_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.in_load |-> !w_cmd_pop)
        else $error("request taken while a load runs");

endmodule : multi_key_rank_select_engine
`default_nettype wire

/* design/mrse_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrse_front: request intake and queue
// Accepts requests, drops unused operation codes, and buffers the rest in a
// short queue for the back end.
// ----------------------------------------------------------------------------
module mrse_front import mrse_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_data,
    output logic          o_cmd_valid,
    output t_in_item      o_cmd,
    input  wire logic     i_cmd_pop
);

    localparam int PW = $clog2(MRSE_QDEPTH);

    t_in_item        r_q [MRSE_QDEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [PW:0]     r_cnt;
    logic            w_full, w_push, w_pop;

    // Classify: only real operations enter the queue
    assign w_full     = (r_cnt == (PW+1)'(MRSE_QDEPTH));
    assign o_in_stall = w_full;
    assign w_push     = i_in_valid && !w_full && (i_in_data.operation inside
                        {OP_LOAD, OP_ORDER, OP_QUERY});
    assign w_pop      = i_cmd_pop && (r_cnt != '0);

    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= i_in_data;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

endmodule : mrse_front
`default_nettype wire

/* design/mrse_list.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrse_list: one sorted index list
// Memory of {key, index} entries. A load walks from the tail, moving each
// entry that sorts after the new key up one place, one entry per cycle.
// ----------------------------------------------------------------------------
module mrse_list import mrse_pkg::*; #(
    parameter int  MAX_RECORDS = MRSE_MAX_RECORDS,
    parameter bit  ASCENDING   = 1'b1,
    localparam int AW          = $clog2(MAX_RECORDS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [AW-1:0] i_n,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [AW-1:0] i_qaddr,
    output logic               o_busy,
    output logic [AW-1:0]      o_rd_idx
);

    localparam int EW = KEY_W + AW;

    logic [EW-1:0]    mem [MAX_RECORDS];
    logic [EW-1:0]    r_rdata;
    logic             r_busy, n_busy;
    logic [AW-1:0]    r_p, n_p;
    logic [KEY_W-1:0] r_key, n_key;
    logic [AW-1:0]    r_idx, n_idx;
    logic             w_wen, w_later;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [EW-1:0]    w_wdata;
    logic [KEY_W-1:0] w_ekey;

    // Does the entry read last cycle sort after the new key (strict: ties stay)
    assign w_ekey  = r_rdata[EW-1:AW];
    assign w_later = ASCENDING ? (w_ekey > r_key) : (w_ekey < r_key);

    // Insertion step; the read for the next place is issued ahead
    always_comb begin
        n_busy  = r_busy;
        n_p     = r_p;
        n_key   = r_key;
        n_idx   = r_idx;
        w_wen   = 1'b0;
        w_waddr = r_p;
        w_wdata = {r_key, r_idx};
        w_raddr = i_qaddr;
        if (i_start) begin
            n_key = i_key;
            n_idx = i_n;
            if (i_n == '0) begin
                w_wen   = 1'b1;
                w_waddr = '0;
                w_wdata = {i_key, i_n};
            end else begin
                w_raddr = i_n - AW'(1);
                n_busy  = 1'b1;
                n_p     = i_n;
            end
        end else if (r_busy) begin
            w_raddr = r_p - AW'(2);
            w_wen   = 1'b1;
            if ((r_p == '0) || !w_later) begin
                n_busy = 1'b0;
            end else begin
                w_wdata = r_rdata;
                n_p     = r_p - AW'(1);
            end
        end
    end

    // List memory
    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        r_p   <= n_p;
        r_key <= n_key;
        r_idx <= n_idx;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    assign o_busy   = r_busy;
    assign o_rd_idx = r_rdata[AW-1:0];

endmodule : mrse_list
`default_nettype wire

/* design/mrse_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrse_back: request execution
// Runs loads into the three sorted lists, keeps the selected order, answers
// rank queries into a one-entry output register.
// ----------------------------------------------------------------------------
module mrse_back import mrse_pkg::*; #(
    parameter int  MAX_RECORDS = MRSE_MAX_RECORDS,
    localparam int AW          = $clog2(MAX_RECORDS)
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cmd_valid,
    input  wire t_in_item i_cmd,
    output logic          o_cmd_pop,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_data,
    output t_back_stat    o_stat
);

    localparam int CW = AW + 1;
    localparam int QW = (CW > RANK_W) ? CW : RANK_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_QRY  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_order, n_order;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    logic          w_start, w_full, w_bad, w_out_free, w_lists_busy;
    logic [AW-1:0] w_qaddr, w_asc_idx, w_dsc_idx, w_rel_idx;
    logic [AW-1:0] w_sel_idx;
    logic          w_asc_busy, w_dsc_busy, w_rel_busy;

    assign w_full     = (r_count >= CW'(MAX_RECORDS));
    assign w_bad      = (i_cmd.rank_position == '0) ||
                        (QW'(i_cmd.rank_position) > QW'(r_count));
    assign w_qaddr    = AW'(i_cmd.rank_position - RANK_W'(1));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_lists_busy = w_asc_busy || w_dsc_busy || w_rel_busy;

    // Sorted lists
    mrse_list #(.MAX_RECORDS(MAX_RECORDS), .ASCENDING(1'b1)) u_asc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_n(r_count[AW-1:0]), .i_key(i_cmd.price), .i_qaddr(w_qaddr),
        .o_busy(w_asc_busy), .o_rd_idx(w_asc_idx)
    );
    mrse_list #(.MAX_RECORDS(MAX_RECORDS), .ASCENDING(1'b0)) u_dsc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_n(r_count[AW-1:0]), .i_key(i_cmd.price), .i_qaddr(w_qaddr),
        .o_busy(w_dsc_busy), .o_rd_idx(w_dsc_idx)
    );
    mrse_list #(.MAX_RECORDS(MAX_RECORDS), .ASCENDING(1'b0)) u_rel (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_n(r_count[AW-1:0]), .i_key(i_cmd.relevance), .i_qaddr(w_qaddr),
        .o_busy(w_rel_busy), .o_rd_idx(w_rel_idx)
    );

    // Pick the list of the current order
    always_comb begin
        case (r_order)
            ORD_CHEAP: w_sel_idx = w_asc_idx;
            ORD_DEAR:  w_sel_idx = w_dsc_idx;
            default:   w_sel_idx = w_rel_idx;
        endcase
    end

    // Control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_order     = r_order;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        w_start     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.operation)
                        OP_LOAD: begin
                            o_cmd_pop = 1'b1;
                            if (!w_full) begin
                                w_start = 1'b1;
                                n_count = r_count + CW'(1);
                                n_state = S_LOAD;
                            end
                        end
                        OP_ORDER: begin
                            o_cmd_pop = 1'b1;
                            n_order   = i_cmd.order_select;
                        end
                        OP_QUERY: begin
                            if (w_out_free) begin
                                o_cmd_pop = 1'b1;
                                if (w_bad) begin
                                    n_out_valid = 1'b1;
                                    n_out       = '{record_index: '0, status: ST_RANGE};
                                end else if (r_order == ORD_LOAD) begin
                                    n_out_valid = 1'b1;
                                    n_out       = '{record_index:
                                        OUT_IDX_W'(i_cmd.rank_position - RANK_W'(1)),
                                        status: ST_OK};
                                end else begin
                                    n_state = S_QRY;
                                end
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                if (!w_lists_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_QRY: begin
                n_out_valid = 1'b1;
                n_out       = '{record_index: OUT_IDX_W'(w_sel_idx), status: ST_OK};
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_order     <= ORD_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_order     <= n_order;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;
    assign o_stat.in_load    = (r_state == S_LOAD);
    assign o_stat.lists_busy = w_lists_busy;

endmodule : mrse_back
`default_nettype wire
